>>> design/ers_pkg.sv
// Shared types and constants for the exponential rank selector.
package ers_pkg;

	localparam int POP_MAX_DEF = 256;

	localparam int BASE_W = 16;
	localparam int SIZE_W = 9;
	localparam int RND_W  = 16;
	localparam int RANK_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int POW_W  = 33;
	localparam int PROD_W = POW_W + BASE_W;

	localparam logic [POW_W-1:0] ONE_Q32 = {1'b1, 32'd0};

	localparam logic [BASE_W-1:0] BASE_RESET = 16'd58982;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd64;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW,
		ST_LHS,
		ST_PRIME,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic {
		MUL_POW,
		MUL_LHS
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     rnd_load;
		logic     pw_one;
		logic     pw_step;
		logic     lhs_load;
	} dp_ctrl_t;

endpackage

>>> design/ers_datapath.sv
// Shared multiplier with the power, product and random value registers.
module ers_datapath
	import ers_pkg::*;
(
	input  logic              clk,
	input  logic [BASE_W-1:0] base,
	input  logic [RND_W-1:0]  random_fraction,
	input  dp_ctrl_t          ctrl,
	output logic              hit
);

	logic [RND_W-1:0]  rnd_q;
	logic [POW_W-1:0]  pw_q;
	logic [PROD_W-1:0] lhs_q;
	logic [POW_W-1:0]  mul_a;
	logic [BASE_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] bound;

	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_POW: begin
				mul_a = pw_q;
				mul_b = base;
			end
			MUL_LHS: begin
				mul_a = ONE_Q32 - pw_q;
				mul_b = rnd_q;
			end
			default: begin
				mul_a = pw_q;
				mul_b = base;
			end
		endcase
	end

	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign bound = {ONE_Q32 - pw_q, {BASE_W{1'b0}}};
	assign hit   = lhs_q < bound;

	always_ff @(posedge clk) begin
		if (ctrl.rnd_load) begin
			rnd_q <= random_fraction;
		end
		if (ctrl.pw_one) begin
			pw_q <= ONE_Q32;
		end else if (ctrl.pw_step) begin
			pw_q <= prod[PROD_W-1:BASE_W];
		end
		if (ctrl.lhs_load) begin
			lhs_q <= prod;
		end
	end

endmodule

>>> design/ers_ctrl.sv
// Sequencer that steps the shared multiplier through the power and rank walk.
module ers_ctrl
	import ers_pkg::*;
#(
	parameter int POP_MAX = POP_MAX_DEF,
	localparam int CNT_W = $clog2(POP_MAX + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CNT_W-1:0] n,
	input  logic             hit,
	input  logic             out_free,
	output logic             in_ready,
	output dp_ctrl_t         ctrl,
	output logic             done,
	output logic [CNT_W-1:0] pick
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pick_q;
	logic             last;

	assign last = (cnt_q == n - CNT_W'(1));
	assign pick = pick_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (n == '0) ? ST_DONE : ST_POW;
				end
			end
			ST_POW: begin
				if (last) begin
					state_d = ST_LHS;
				end
			end
			ST_LHS:   state_d = ST_PRIME;
			ST_PRIME: state_d = ST_WALK;
			ST_WALK: begin
				if (hit || last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		done          = 1'b0;
		ctrl.mul_sel  = MUL_POW;
		ctrl.rnd_load = 1'b0;
		ctrl.pw_one   = 1'b0;
		ctrl.pw_step  = 1'b0;
		ctrl.lhs_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				ctrl.rnd_load = in_valid;
				ctrl.pw_one   = in_valid;
			end
			ST_POW: begin
				ctrl.pw_step = 1'b1;
			end
			ST_LHS: begin
				ctrl.mul_sel  = MUL_LHS;
				ctrl.lhs_load = 1'b1;
				ctrl.pw_one   = 1'b1;
			end
			ST_PRIME: begin
				ctrl.pw_step = 1'b1;
			end
			ST_WALK: begin
				ctrl.pw_step = 1'b1;
			end
			ST_DONE: begin
				done = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pick_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					pick_q <= '0;
				end
				ST_POW: begin
					cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
				end
				ST_WALK: begin
					if (hit) begin
						pick_q <= cnt_q;
					end else if (!last) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POW || state_q == ST_WALK) |-> cnt_q < n)
		else $error("rank counter ran past the population size");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pick_q < n || pick_q == '0))
		else $error("selected rank outside the population");

	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_free)
		else $error("result finished while the output register is full");

	a_walk_after_prime: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRIME |=> state_q == ST_WALK)
		else $error("walk did not follow the first power step");

endmodule

>>> design/exponential_rank_selector.sv
// Top level of the exponential rank selector with configuration and output registers.
// The sequencer accepts a new item only while idle, once the previous result has entered
// the output register; an empty population goes straight to the done state. The single
// shared multiplier forms one power of the base per cycle, first up to c^N and then rank
// by rank, where N is the clamped population size.
// Reset clears the sequencer and output valid and loads the register defaults.
module exponential_rank_selector
	import ers_pkg::*;
#(
	parameter int POP_MAX = POP_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RND_W-1:0]      random_fraction,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RANK_W-1:0]     selected_rank,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(POP_MAX + 1);
	localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n;
	logic [CMP_W-1:0]  size_ext;
	logic [CMP_W-1:0]  max_ext;
	logic              hit;
	logic              done;
	logic              out_free;
	logic [CNT_W-1:0]  pick;
	logic [CNT_W+RANK_W-1:0] pick_ext;
	logic              out_valid_q;
	logic [RANK_W-1:0] rank_q;
	dp_ctrl_t          ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASE: base_q <= cfg_data[BASE_W-1:0];
				CFG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				default:  base_q <= base_q;
			endcase
		end
	end

	assign size_ext = CMP_W'(size_q);
	assign max_ext  = CMP_W'(POP_MAX);
	assign n = (size_ext > max_ext) ? CNT_W'(POP_MAX) : size_ext[CNT_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	ers_ctrl #(
		.POP_MAX (POP_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.n        (n),
		.hit      (hit),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl),
		.done     (done),
		.pick     (pick)
	);

	ers_datapath u_datapath (
		.clk             (clk),
		.base            (base_q),
		.random_fraction (random_fraction),
		.ctrl            (ctrl),
		.hit             (hit)
	);

	assign pick_ext = {{RANK_W{1'b0}}, pick};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rank_q <= pick_ext[RANK_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign selected_rank = rank_q;

endmodule
